[hdl/pffla_pkg.sv]
package pffla_pkg;

    // Request codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_HIGH = 1'd1;

    // Free page counter
    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

endpackage

[hdl/page_frame_free_list_allocator_unit.sv]
// Page frame allocator, LIFO free list of physical pages.
// Request channel: a request (opcode, page_address) is taken at a rising edge
// with start high and busy low. Opcodes: allocate, free, initialize.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_granted_address and o_pages_free; there is no backpressure, the result
// must be captured in that cycle.
// Configuration channel: i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data writes ram_low_address (index 0) or ram_high_address (index 1);
// write only while no request is in flight. o_cfg_ready is always high.
// Timing: allocate, free and unused opcodes pass through S_OP and o_done is
// high as the block returns to S_IDLE; busy is low in the same cycle as
// o_done, so a new request may be issued while the result is shown. The next
// link of the head page is read from the link memory on acceptance, ready
// for the allocate in S_OP. Initialize then walks S_WALK for the N pages
// placed on the list (at most MAX_PAGES): the link memory has one write
// port, one link per cycle.
// Reset: list empty, free count zero, both address registers zero. The link
// memory is not cleared, so a link may be read before it is written.
module page_frame_free_list_allocator_unit
    import pffla_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_opcode,
    input  logic [31:0]          i_page_address,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [31:0]          o_granted_address,
    output logic [CNT_W-1:0]     o_pages_free,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int PB_W   = $clog2(PAGE_BYTES);
    localparam int PN_W   = 32 - PB_W;
    localparam int SLOT_W = $clog2(MAX_PAGES);
    localparam int N_W    = $clog2(MAX_PAGES + 1);
    localparam int LINK_W = PN_W + 1;
    localparam logic [31:0] MAX_W = 32'(MAX_PAGES);
    localparam logic [CNT_W-1:0] CNT_LIM =
        (MAX_PAGES < int'(COUNT_MAX)) ? CNT_W'(MAX_PAGES) : COUNT_MAX;

    typedef enum logic [1:0] {S_IDLE, S_OP, S_WALK} t_state;

    t_state            r_state;
    logic [31:0]       r_ram_low;
    logic [31:0]       r_ram_high;
    logic              r_head_valid;
    logic [PN_W-1:0]   r_head_page;
    logic [CNT_W-1:0]  r_count;
    logic              r_done;
    logic [1:0]        r_status;
    logic [31:0]       r_granted;

    // Request payload and checks captured on acceptance
    logic [1:0]        r_op;
    logic              r_bad_align;
    logic              r_bad_range;
    logic [SLOT_W-1:0] r_slot;
    logic [PN_W-1:0]   r_page;
    logic              r_head_in;

    // Initialize walk
    logic [N_W-1:0]    r_walk_n;
    logic [N_W-1:0]    r_k;

    // Link memory: {valid, next page} per slot
    logic [LINK_W-1:0] r_link_mem [MAX_PAGES];
    logic [LINK_W-1:0] r_rdata;

    logic              accept;
    logic [PN_W:0]     base_page;
    logic [PN_W:0]     head_ext;
    logic [PN_W:0]     head_diff;
    logic              head_in;
    logic [PN_W:0]     req_page;
    logic [PN_W:0]     req_diff;
    logic              req_bad_range;
    logic [PN_W:0]     top_page;
    logic [PN_W:0]     span;
    logic [N_W-1:0]    init_n;
    logic              walk_last;
    logic [PN_W:0]     walk_next;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    logic [LINK_W-1:0] mem_wd;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Base page is the first whole page at or above ram_low_address
    assign base_page = {1'b0, r_ram_low[31:PB_W]} + (PN_W + 1)'(|r_ram_low[PB_W-1:0]);

    // Map head page to its link slot
    assign head_ext  = {1'b0, r_head_page};
    assign head_diff = head_ext - base_page;
    assign head_in   = (head_ext >= base_page) && (32'(head_diff) < MAX_W);

    // Range check for a page being freed
    assign req_page      = {1'b0, i_page_address[31:PB_W]};
    assign req_diff      = req_page - base_page;
    assign req_bad_range = (i_page_address < r_ram_low) || (i_page_address >= r_ram_high) ||
                           (req_page < base_page) || (32'(req_diff) >= MAX_W);

    // Number of pages that initialize places on the list
    assign top_page = {1'b0, r_ram_high[31:PB_W]};
    assign span     = top_page - base_page;
    always_comb begin
        if (top_page <= base_page) begin
            init_n = '0;
        end else if (32'(span) > MAX_W) begin
            init_n = N_W'(MAX_PAGES);
        end else begin
            init_n = N_W'(span);
        end
    end

    assign walk_last = (r_k == r_walk_n - N_W'(1));
    assign walk_next = base_page + (PN_W + 1)'(r_k) + (PN_W + 1)'(1);

    // Link memory write: push on free, build list on initialize
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_slot;
        mem_wd = {r_head_valid, r_head_page};
        case (r_state)
            S_OP: begin
                mem_we = (r_op == OP_FREE) && !r_bad_align && !r_bad_range;
            end
            S_WALK: begin
                mem_we = 1'b1;
                mem_wa = r_k[SLOT_W-1:0];
                mem_wd = {!walk_last, walk_next[PN_W-1:0]};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Memory port: write, and read the head link on acceptance
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rdata <= r_link_mem[head_diff[SLOT_W-1:0]];
        end
    end

    // Capture request payload and checks
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_opcode;
            r_bad_align <= |i_page_address[PB_W-1:0];
            r_bad_range <= req_bad_range;
            r_slot      <= req_diff[SLOT_W-1:0];
            r_page      <= i_page_address[31:PB_W];
            r_head_in   <= head_in;
        end
    end

    // Control, list state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ram_low    <= '0;
            r_ram_high   <= '0;
            r_head_valid <= 1'b0;
            r_head_page  <= '0;
            r_count      <= '0;
            r_done       <= 1'b0;
            r_status     <= ST_OK;
            r_granted    <= '0;
            r_walk_n     <= '0;
            r_k          <= '0;
        end else begin
            r_done <= 1'b0;

            // Register writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_RAM_LOW:  r_ram_low  <= i_cfg_data;
                    REG_RAM_HIGH: r_ram_high <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    r_status  <= ST_OK;
                    r_granted <= '0;
                    r_state   <= S_IDLE;
                    r_done    <= 1'b1;
                    case (r_op)
                        OP_ALLOC: begin
                            if (!r_head_valid) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_granted <= {r_head_page, {PB_W{1'b0}}};
                                if (r_head_in) begin
                                    r_head_valid <= r_rdata[LINK_W-1];
                                    r_head_page  <= r_rdata[PN_W-1:0];
                                end else begin
                                    r_head_valid <= 1'b0;
                                    r_head_page  <= '0;
                                end
                                if (r_count != '0) begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                            end
                        end
                        OP_FREE: begin
                            if (r_bad_align) begin
                                r_status <= ST_ALIGN;
                            end else if (r_bad_range) begin
                                r_status <= ST_RANGE;
                            end else begin
                                r_head_valid <= 1'b1;
                                r_head_page  <= r_page;
                                if (r_count < CNT_LIM) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                        end
                        OP_INIT: begin
                            r_head_valid <= 1'b0;
                            r_head_page  <= '0;
                            r_count      <= '0;
                            r_walk_n     <= init_n;
                            r_k          <= '0;
                            if (init_n != '0) begin
                                r_state <= S_WALK;
                                r_done  <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_WALK: begin
                    r_k <= r_k + N_W'(1);
                    if (walk_last) begin
                        r_head_valid <= 1'b1;
                        r_head_page  <= base_page[PN_W-1:0];
                        r_count      <= (32'(r_walk_n) > 32'(CNT_LIM)) ?
                                        CNT_LIM : CNT_W'(r_walk_n);
                        r_status     <= ST_OK;
                        r_granted    <= '0;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_pages_free      = r_count;

endmodule

[hdl/pffla_checker.sv]
module pffla_checker
    import pffla_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [1:0]           i_opcode,
    input logic                 o_done,
    input logic [1:0]           o_status,
    input logic [31:0]          o_granted_address
);

    // Accepted transaction always occupies the block for its first cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // Allocate, free and unused opcodes answer straight from S_OP after acceptance
    a_short_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode != OP_INIT |-> ##2 o_done)
        else $error("result missing two cycles after short transaction");

    // Result shows only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // Results never come in adjacent cycles
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A failed request never grants an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_granted_address == 32'd0)
        else $error("address granted with error status");

endmodule

bind page_frame_free_list_allocator_unit pffla_checker u_pffla_checker (.*);

[bench/page_frame_free_list_allocator_unit_tb.sv]
`timescale 1ns / 100ps

module page_frame_free_list_allocator_unit_tb;
    import pffla_pkg::*;

    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_PAGES     = 4096;
    localparam int RANDOM_ITEMS  = 1720;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_LIMIT  = 10;

    // Opcode with no function; the block answers it without touching the list
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      granted;
        logic [CNT_W-1:0] pages_free;
    } t_page_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_opcode = OP_ALLOC;
    logic [31:0]      i_page_address = '0;
    logic             o_done;
    logic [1:0]       o_status;
    logic [31:0]      o_granted_address;
    logic [CNT_W-1:0] o_pages_free;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_RAM_LOW;
    logic [31:0]      i_cfg_data = '0;

    page_frame_free_list_allocator_unit #(
        .PAGE_BYTES(PAGE_BYTES),
        .MAX_PAGES (MAX_PAGES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_page_address   (i_page_address),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_address(o_granted_address),
        .o_pages_free     (o_pages_free),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Tracked free list: head, per-slot next links, free page count, window
    logic [31:0] ram_low = '0;
    logic [31:0] ram_high = '0;
    logic        head_ok = 1'b0;
    logic [19:0] head_page = '0;
    logic        link_ok [MAX_PAGES];
    logic [19:0] link_page [MAX_PAGES];
    int          list_count = 0;

    t_page_answer page_answers_due[$];
    logic [31:0]  granted_pages[$];

    int idle_pct = 24;
    int mismatches = 0;
    int results_seen = 0;
    int grants = 0;
    int empties = 0;
    int frees_taken = 0;
    int rejects = 0;
    int rebuilds = 0;
    int windows = 0;
    int cycle_count = 0;

    // Push one page on the tracked list; count saturates at table size
    function automatic void push_tracked_page(logic [19:0] page, longint slot);
        link_ok[slot]   = head_ok;
        link_page[slot] = head_page;
        head_ok   = 1'b1;
        head_page = page;
        if (list_count < COUNT_MAX && list_count < MAX_PAGES)
            list_count++;
    endfunction

    // Apply one request to the tracked list and return the answer it should give
    function automatic t_page_answer apply_page_request(logic [1:0] op, logic [31:0] addr);
        t_page_answer ans;
        longint base;
        longint page;
        longint top;
        longint n;
        longint slot;
        ans.status  = ST_OK;
        ans.granted = '0;
        base = ({32'd0, ram_low} + PAGE_BYTES - 1) / PAGE_BYTES;
        case (op)
            OP_ALLOC: begin
                if (!head_ok) begin
                    ans.status = ST_EMPTY;
                end else begin
                    page = head_page;
                    ans.granted = 32'(page * PAGE_BYTES);
                    if (page >= base && page - base < MAX_PAGES) begin
                        slot = page - base;
                        head_ok   = link_ok[slot];
                        head_page = link_page[slot];
                    end else begin
                        // head no longer maps to a slot: grant it, empty the list
                        head_ok   = 1'b0;
                        head_page = '0;
                    end
                    if (list_count > 0)
                        list_count--;
                end
            end
            OP_FREE: begin
                if (addr % PAGE_BYTES != 0) begin
                    ans.status = ST_ALIGN;
                end else if (addr < ram_low || addr >= ram_high) begin
                    ans.status = ST_RANGE;
                end else begin
                    page = addr / PAGE_BYTES;
                    if (page < base || page - base >= MAX_PAGES)
                        ans.status = ST_RANGE;
                    else
                        push_tracked_page(page[19:0], page - base);
                end
            end
            OP_INIT: begin
                top = ram_high / PAGE_BYTES;
                head_ok    = 1'b0;
                head_page  = '0;
                list_count = 0;
                if (top > base) begin
                    n = top - base;
                    if (n > MAX_PAGES)
                        n = MAX_PAGES;
                    // push from the top down so the list ends up ascending
                    for (longint i = n - 1; i >= 0; i--)
                        push_tracked_page(20'(base + i), i);
                end
            end
            default: ;
        endcase
        ans.pages_free = CNT_W'(list_count);
        return ans;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Hold start low for a random gap, or none, before the request
    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Present one request and wait for its transaction, then queue its answer
    task automatic send_request(input logic [1:0] op, input logic [31:0] addr);
        t_page_answer ans;
        sender_gap();
        start          <= 1'b1;
        i_opcode       <= op;
        i_page_address <= addr;
        do @(posedge i_clk); while (busy);
        ans = apply_page_request(op, addr);
        page_answers_due.push_back(ans);
        case (op)
            OP_ALLOC: begin
                if (ans.status == ST_OK) begin
                    grants++;
                    granted_pages.push_back(ans.granted);
                end else begin
                    empties++;
                end
            end
            OP_FREE: begin
                if (ans.status == ST_OK)
                    frees_taken++;
                else
                    rejects++;
            end
            OP_INIT: begin
                rebuilds++;
                granted_pages.delete();
            end
            default: ;
        endcase
    endtask

    // Drop start and wait until every answer is back and the block has settled
    task automatic drain_answers();
        start <= 1'b0;
        while (page_answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both window registers back to back, valid held across them
    task automatic set_ram_window(input logic [31:0] low_addr, input logic [31:0] high_addr);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_RAM_LOW;
        i_cfg_data  <= low_addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        ram_low = low_addr;
        i_cfg_index <= REG_RAM_HIGH;
        i_cfg_data  <= high_addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        ram_high = high_addr;
        i_cfg_valid <= 1'b0;
        windows++;
    endtask

    // Check every result against the oldest queued answer
    always @(posedge i_clk) begin : check_answers
        t_page_answer want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (page_answers_due.size() == 0) begin
                log_mismatch("result with no request outstanding", '0, o_granted_address);
            end else begin
                want = page_answers_due.pop_front();
                if (o_status !== want.status)
                    log_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_granted_address !== want.granted)
                    log_mismatch("granted address", want.granted, o_granted_address);
                if (o_pages_free !== want.pages_free)
                    log_mismatch("pages free", 32'(want.pages_free), 32'(o_pages_free));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, page_answers_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Empty list, zero window, unused opcode, all-ones misaligned address
    task automatic test_block_after_reset();
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'h0);
    endtask

    // Unaligned low bound rounds the base up; top partial page is not listed
    task automatic test_short_list();
        drain_answers();
        set_ram_window(32'h0000_0001, 32'h0000_3800);
        send_request(OP_INIT, 32'h0);
        repeat (3) send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0000_2000);
        send_request(OP_FREE, 32'h0000_3800);
        send_request(OP_FREE, 32'h0000_0000);
    endtask

    // Page zero granted at address zero; end bound excluded; double free
    // loops the list so the count bottoms out while pages still come back
    task automatic test_page_zero_and_double_free();
        drain_answers();
        set_ram_window(32'h0, 32'h0000_2000);
        send_request(OP_INIT, 32'h0);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0000_2000);
        send_request(OP_FREE, 32'h0000_1000);
        repeat (3) send_request(OP_ALLOC, 32'h0);
    endtask

    // High bound below low bound: empty list, every free out of range
    task automatic test_inverted_window();
        drain_answers();
        set_ram_window(32'h0000_5000, 32'h0000_4000);
        send_request(OP_INIT, 32'h0);
        send_request(OP_FREE, 32'h0000_4000);
    endtask

    // More RAM than the table holds: only the lowest pages are listed,
    // count saturates on a double free, pages past the table are rejected
    task automatic test_oversized_ram();
        drain_answers();
        set_ram_window(32'h0, 32'hFFFF_FFFF);
        send_request(OP_INIT, 32'h0);
        send_request(OP_FREE, 32'h0);
        send_request(OP_FREE, 32'h0100_0000);
    endtask

    // Move the window so the head page falls below, then above, the table
    task automatic test_head_outside_table();
        drain_answers();
        set_ram_window(32'h0001_0000, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);
        drain_answers();
        set_ram_window(32'h0100_0000, 32'h0100_2000);
        send_request(OP_INIT, 32'h0);
        drain_answers();
        set_ram_window(32'h0, 32'h0100_2000);
        send_request(OP_ALLOC, 32'h0);
    endtask

    // Pick a window: mostly a few dozen pages, sometimes an extreme
    task automatic pick_window(output logic [31:0] low_addr, output logic [31:0] high_addr);
        longint top;
        case ($urandom_range(15))
            0: begin
                low_addr  = '0;
                high_addr = '1;
            end
            1: begin
                low_addr  = '1;
                high_addr = '1;
            end
            2: begin
                low_addr  = $urandom;
                high_addr = $urandom_range(low_addr, 0);
            end
            3: begin
                low_addr  = '0;
                high_addr = $urandom_range(24, 1) * PAGE_BYTES;
            end
            default: begin
                low_addr = $urandom_range(32'hFFF0_0000, 0);
                if ($urandom_range(3) != 0)
                    low_addr = low_addr / PAGE_BYTES * PAGE_BYTES;
                top = ({32'd0, low_addr} + PAGE_BYTES - 1) / PAGE_BYTES
                      + $urandom_range(48, 0);
                top = top * PAGE_BYTES;
                if ($urandom_range(3) == 0)
                    top = top + $urandom_range(PAGE_BYTES - 1, 0);
                high_addr = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(top);
            end
        endcase
    endtask

    // One random request: mostly alloc and return of granted pages, some noise
    task automatic random_request();
        int pick;
        int idx;
        logic [31:0] a;
        logic [31:0] lo_pg;
        logic [31:0] hi_pg;
        pick = $urandom_range(99);
        if (pick < 38) begin
            send_request(OP_ALLOC, $urandom);
        end else if (pick < 72) begin
            if (granted_pages.size() != 0) begin
                idx = $urandom_range(granted_pages.size() - 1);
                a = granted_pages[idx];
                granted_pages.delete(idx);
                send_request(OP_FREE, a);
            end else begin
                send_request(OP_ALLOC, $urandom);
            end
        end else if (pick < 80) begin
            // aligned page near the window: double free, unlisted page, edges
            lo_pg = ram_low / PAGE_BYTES;
            hi_pg = ram_high / PAGE_BYTES;
            if (hi_pg >= lo_pg)
                a = $urandom_range(hi_pg, lo_pg) * PAGE_BYTES;
            else
                a = $urandom / PAGE_BYTES * PAGE_BYTES;
            send_request(OP_FREE, a);
        end else if (pick < 86) begin
            a = $urandom;
            a[11:0] = 12'($urandom_range(PAGE_BYTES - 1, 1));
            send_request(OP_FREE, a);
        end else if (pick < 92) begin
            send_request(OP_FREE, $urandom);
        end else if (pick < 97) begin
            send_request(OP_UNUSED, $urandom);
        end else begin
            send_request(OP_INIT, $urandom);
        end
    endtask

    // Phases of random traffic, each on a fresh window rebuilt right away
    task automatic test_random_traffic();
        int done_items;
        int phase_len;
        logic [31:0] low_addr;
        logic [31:0] high_addr;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            drain_answers();
            pick_window(low_addr, high_addr);
            set_ram_window(low_addr, high_addr);
            send_request(OP_INIT, $urandom);
            done_items++;
            phase_len = $urandom_range(90, 30);
            for (int k = 0; k < phase_len && done_items < RANDOM_ITEMS; k++) begin
                if (done_items * 3 < RANDOM_ITEMS)
                    idle_pct = 24;
                else if (done_items * 3 < 2 * RANDOM_ITEMS)
                    idle_pct = 76;
                else
                    idle_pct = 0;
                random_request();
                done_items++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_block_after_reset();
        test_short_list();
        test_page_zero_and_double_free();
        test_inverted_window();
        test_oversized_ram();
        test_head_outside_table();
        test_random_traffic();
        drain_answers();

        $display("Checked %0d results over %0d address windows and %0d list rebuilds",
                 results_seen, windows, rebuilds);
        $display("Grants %0d, empty allocs %0d, frees taken %0d, frees rejected %0d",
                 grants, empties, frees_taken, rejects);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
